@@ src/partition_fit_allocator_core_macros.svh @@
// assertion helpers for the allocator walk module
`ifndef PARTITION_FIT_ALLOCATOR_CORE_MACROS_SVH
`define PARTITION_FIT_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define PFA_ASSERT_IMPLY(name, clk, rst_n, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("allocator check failed");

// next-cycle implication
`define PFA_ASSERT_NEXT(name, clk, rst_n, cond, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("allocator sequence check failed");

`endif

@@ src/pfa_pkg.sv @@
package pfa_pkg;

    localparam int MAX_PARTITIONS_DEF = 64;
    localparam int SIZE_BITS_DEF      = 8;

    localparam int POLICY_W   = 2;
    localparam int HOLD_W     = 4;
    localparam int COUNT_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int AGE_W      = 4;

    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;
    localparam logic [POLICY_W-1:0] POLICY_SPLIT = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTITION_COUNT = 2'd2;

    localparam logic [POLICY_W-1:0] POLICY_RESET = POLICY_FIRST;
    localparam logic [HOLD_W-1:0]   HOLD_RESET   = 4'd5;
    localparam logic [COUNT_W-1:0]  COUNT_RESET  = 7'd0;

    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_ALLOC = 1'b1;

    typedef struct packed {
        logic [POLICY_W-1:0] fit_policy;
        logic [HOLD_W-1:0]   hold_time;
    } cfg_t;

endpackage

@@ src/pfa_cfg.sv @@
module pfa_cfg #(
    parameter int MAX_PARTITIONS = pfa_pkg::MAX_PARTITIONS_DEF,
    parameter int CNT_W          = $clog2(MAX_PARTITIONS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data,
    output pfa_pkg::cfg_t                 cfg,
    output logic [CNT_W-1:0]              limit
);

    logic [pfa_pkg::POLICY_W-1:0] policy_reg;
    logic [pfa_pkg::HOLD_W-1:0]   hold_reg;
    logic [pfa_pkg::COUNT_W-1:0]  count_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= pfa_pkg::POLICY_RESET;
            hold_reg   <= pfa_pkg::HOLD_RESET;
            count_reg  <= pfa_pkg::COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pfa_pkg::CFG_FIT_POLICY:
                    policy_reg <= cfg_data[pfa_pkg::POLICY_W-1:0];
                pfa_pkg::CFG_HOLD_TIME:
                    hold_reg <= cfg_data[pfa_pkg::HOLD_W-1:0];
                pfa_pkg::CFG_PARTITION_COUNT:
                    count_reg <= cfg_data[pfa_pkg::COUNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // clamp the walk length to the table depth
    always_comb
    begin
        if (32'(count_reg) > MAX_PARTITIONS)
            limit = CNT_W'(MAX_PARTITIONS);
        else
            limit = CNT_W'(count_reg);
    end

    assign cfg.fit_policy = policy_reg;
    assign cfg.hold_time  = hold_reg;

endmodule

@@ src/pfa_walk.sv @@
`include "partition_fit_allocator_core_macros.svh"

module pfa_walk #(
    parameter int MAX_PARTITIONS = pfa_pkg::MAX_PARTITIONS_DEF,
    parameter int SIZE_BITS      = pfa_pkg::SIZE_BITS_DEF,
    parameter int IDX_W          = $clog2(MAX_PARTITIONS),
    parameter int CNT_W          = $clog2(MAX_PARTITIONS + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic                 req_type,
    input  logic [IDX_W-1:0]     part_index,
    input  logic [SIZE_BITS-1:0] part_size,
    input  logic [SIZE_BITS-1:0] proc_size,
    input  pfa_pkg::cfg_t        cfg,
    input  logic [CNT_W-1:0]     limit,
    output logic                 res_valid,
    input  logic                 res_take,
    output logic                 res_granted,
    output logic [IDX_W-1:0]     res_idx,
    output logic [SIZE_BITS-1:0] res_room
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_LOAD  = 3'd2;
    localparam logic [2:0] S_ISSUE = 3'd3;
    localparam logic [2:0] S_WALK  = 3'd4;
    localparam logic [2:0] S_PLACE = 3'd5;
    localparam logic [2:0] S_FIN   = 3'd6;

    localparam int AGE_W = pfa_pkg::AGE_W;

    typedef struct packed {
        logic [SIZE_BITS-1:0] size;
        logic [SIZE_BITS-1:0] occ;
        logic [AGE_W-1:0]     age;
    } entry_t;

    function automatic logic [SIZE_BITS-1:0] room_of(input logic [SIZE_BITS-1:0] s,
                                                    input logic [SIZE_BITS-1:0] o);
        room_of = (s >= o) ? s - o : '0;
    endfunction

    entry_t mem [MAX_PARTITIONS];
    entry_t rd_entry;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [IDX_W-1:0]  mem_raddr;
    entry_t            mem_wdata;

    logic [2:0]           state_reg, state_next;
    logic [IDX_W-1:0]     cur_reg, cur_next;
    logic [IDX_W-1:0]     resume_reg, resume_next;
    logic [SIZE_BITS-1:0] sz_reg, sz_next;
    logic                 found_reg, found_next;
    logic [IDX_W-1:0]     pick_reg, pick_next;
    logic [SIZE_BITS-1:0] pick_room_reg, pick_room_next;
    logic [SIZE_BITS-1:0] pick_size_reg, pick_size_next;
    logic                 granted_reg, granted_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [SIZE_BITS-1:0] room_reg, room_next;

    logic                 resume_walk;
    logic                 split;
    logic                 worst;
    logic [SIZE_BITS-1:0] room_d;
    logic [AGE_W:0]       age_inc;
    logic                 released;
    logic [SIZE_BITS-1:0] occ_sum;
    logic                 better;
    logic [CNT_W-1:0]     next_pos;
    logic                 last;
    logic                 hit;
    logic                 in_range;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_entry <= mem[mem_raddr];
    end

    assign resume_walk = (cfg.fit_policy == pfa_pkg::POLICY_FIRST) ||
                         (cfg.fit_policy == pfa_pkg::POLICY_SPLIT);
    assign split       = (cfg.fit_policy == pfa_pkg::POLICY_SPLIT);
    assign worst       = (cfg.fit_policy == pfa_pkg::POLICY_WORST);
    assign room_d      = room_of(rd_entry.size, rd_entry.occ);
    assign age_inc     = {1'b0, rd_entry.age} + (AGE_W + 1)'(1);
    assign released    = age_inc > {1'b0, cfg.hold_time};
    assign occ_sum     = rd_entry.occ + sz_reg;
    assign better      = !found_reg || (worst ? (room_d > pick_room_reg)
                                              : (room_d < pick_room_reg));
    assign next_pos    = CNT_W'(cur_reg) + CNT_W'(1);
    assign last        = next_pos >= limit;
    assign in_range    = 32'(cur_reg) < MAX_PARTITIONS;

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        resume_next    = resume_reg;
        sz_next        = sz_reg;
        found_next     = found_reg;
        pick_next      = pick_reg;
        pick_room_next = pick_room_reg;
        pick_size_next = pick_size_reg;
        granted_next   = granted_reg;
        idx_next       = idx_reg;
        room_next      = room_reg;
        mem_we         = 1'b0;
        mem_waddr      = cur_reg;
        mem_raddr      = cur_reg;
        mem_wdata      = '0;
        in_stall       = 1'b1;
        hit            = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                if (cur_reg == IDX_W'(MAX_PARTITIONS - 1))
                begin
                    cur_next   = '0;
                    state_next = S_IDLE;
                end
                else
                    cur_next = cur_reg + IDX_W'(1);
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    found_next = 1'b0;
                    if (req_type == pfa_pkg::REQ_LOAD)
                    begin
                        sz_next    = part_size;
                        cur_next   = part_index;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        sz_next    = proc_size;
                        cur_next   = resume_walk ? resume_reg : '0;
                        state_next = S_ISSUE;
                    end
                end
            end
            S_LOAD:
            begin
                mem_we         = in_range;
                mem_wdata.size = sz_reg;
                granted_next   = in_range;
                idx_next       = in_range ? cur_reg : '0;
                room_next      = in_range ? sz_reg : '0;
                state_next     = S_FIN;
            end
            S_ISSUE:
            begin
                if (CNT_W'(cur_reg) >= limit)
                begin
                    if (resume_walk)
                        resume_next = '0;
                    granted_next = 1'b0;
                    idx_next     = '0;
                    room_next    = '0;
                    state_next   = S_FIN;
                end
                else
                    state_next = S_WALK;
            end
            S_WALK:
            begin
                mem_raddr      = IDX_W'(next_pos);
                mem_wdata.size = rd_entry.size;
                if (rd_entry.occ != '0)
                begin
                    mem_we = 1'b1;
                    if (released)
                    begin
                        mem_wdata.occ = '0;
                        mem_wdata.age = '0;
                    end
                    else if (split && (room_d >= sz_reg))
                    begin
                        mem_wdata.occ = occ_sum;
                        mem_wdata.age = AGE_W'(1);
                        hit           = 1'b1;
                    end
                    else
                    begin
                        mem_wdata.occ = rd_entry.occ;
                        mem_wdata.age = age_inc[AGE_W-1:0];
                    end
                end
                else if (resume_walk)
                begin
                    if ((sz_reg <= room_d) && (split || (room_d != '0)))
                    begin
                        mem_we        = 1'b1;
                        mem_wdata.occ = occ_sum;
                        mem_wdata.age = AGE_W'(1);
                        hit           = 1'b1;
                    end
                end
                else if ((room_d >= sz_reg) && better)
                begin
                    found_next     = 1'b1;
                    pick_next      = cur_reg;
                    pick_room_next = room_d;
                    pick_size_next = rd_entry.size;
                end

                if (hit)
                begin
                    resume_next  = cur_reg;
                    granted_next = 1'b1;
                    idx_next     = cur_reg;
                    room_next    = room_of(rd_entry.size, occ_sum);
                    state_next   = S_FIN;
                end
                else if (last)
                begin
                    if (resume_walk)
                        resume_next = '0;
                    if (!resume_walk && found_next)
                        state_next = S_PLACE;
                    else
                    begin
                        granted_next = 1'b0;
                        idx_next     = '0;
                        room_next    = '0;
                        state_next   = S_FIN;
                    end
                end
                else
                    cur_next = IDX_W'(next_pos);
            end
            S_PLACE:
            begin
                mem_we         = 1'b1;
                mem_waddr      = pick_reg;
                mem_wdata.size = pick_size_reg;
                mem_wdata.occ  = sz_reg;
                mem_wdata.age  = AGE_W'(1);
                granted_next   = 1'b1;
                idx_next       = pick_reg;
                room_next      = room_of(pick_size_reg, sz_reg);
                state_next     = S_FIN;
            end
            S_FIN:
            begin
                if (res_take)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            cur_reg    <= '0;
            resume_reg <= '0;
            found_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cur_reg    <= cur_next;
            resume_reg <= resume_next;
            found_reg  <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sz_reg        <= sz_next;
        pick_reg      <= pick_next;
        pick_room_reg <= pick_room_next;
        pick_size_reg <= pick_size_next;
        granted_reg   <= granted_next;
        idx_reg       <= idx_next;
        room_reg      <= room_next;
    end

    assign res_valid   = (state_reg == S_FIN);
    assign res_granted = granted_reg;
    assign res_idx     = idx_reg;
    assign res_room    = room_reg;

    `PFA_ASSERT_IMPLY(a_walk_in_range, clk, rst_n, state_reg == S_WALK, CNT_W'(cur_reg) < limit)
    `PFA_ASSERT_IMPLY(a_no_write_idle, clk, rst_n, state_reg == S_IDLE || state_reg == S_FIN, !mem_we)
    `PFA_ASSERT_IMPLY(a_walk_no_overlap, clk, rst_n, state_reg == S_WALK && mem_we, mem_waddr != mem_raddr)
    `PFA_ASSERT_IMPLY(a_place_has_pick, clk, rst_n, state_reg == S_PLACE, found_reg)
    `PFA_ASSERT_NEXT(a_place_then_fin, clk, rst_n, state_reg == S_PLACE, state_reg == S_FIN)

endmodule

@@ src/pfa_outreg.sv @@
module pfa_outreg #(
    parameter int SIZE_BITS = pfa_pkg::SIZE_BITS_DEF,
    parameter int IDX_W     = $clog2(pfa_pkg::MAX_PARTITIONS_DEF)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    output logic                 res_take,
    input  logic                 res_granted,
    input  logic [IDX_W-1:0]     res_idx,
    input  logic [SIZE_BITS-1:0] res_room,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 granted,
    output logic [IDX_W-1:0]     placed_index,
    output logic [SIZE_BITS-1:0] room_left
);

    logic                 valid_reg;
    logic                 granted_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [SIZE_BITS-1:0] room_reg;

    // slot is free when empty or its word leaves this cycle
    assign res_take = res_valid && (!valid_reg || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (res_take)
            valid_reg <= 1'b1;
        else if (!out_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            granted_reg <= res_granted;
            idx_reg     <= res_idx;
            room_reg    <= res_room;
        end
    end

    assign out_valid    = valid_reg;
    assign granted      = granted_reg;
    assign placed_index = idx_reg;
    assign room_left    = room_reg;

endmodule

@@ src/partition_fit_allocator_core.sv @@
// Fixed-partition allocator. A load word (req_type 0) writes one partition's size and empties
// it; an allocate word (req_type 1) walks the partition table, ages and releases occupied
// partitions and places the process by fit_policy, answering with granted, placed_index and
// room_left. The table sits in a RAM with one registered read port and one write port and is
// swept one entry per cycle; the walk covers n = min(partition_count, MAX_PARTITIONS)
// partitions (fewer for first fit and splitting, which start at the last placement and stop
// at a hit), and best and worst fit add a placement write after the walk. After reset the
// block clears every table entry before it takes its first word; configuration writes are
// taken at any time. A finished word waits in the output register while the next word is
// accepted.
module partition_fit_allocator_core #(
    parameter int MAX_PARTITIONS = pfa_pkg::MAX_PARTITIONS_DEF,
    parameter int SIZE_BITS      = pfa_pkg::SIZE_BITS_DEF,
    parameter int IDX_W          = $clog2(MAX_PARTITIONS),
    parameter int CNT_W          = $clog2(MAX_PARTITIONS + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          req_type,
    input  logic [IDX_W-1:0]              part_index,
    input  logic [SIZE_BITS-1:0]          part_size,
    input  logic [SIZE_BITS-1:0]          proc_size,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          granted,
    output logic [IDX_W-1:0]              placed_index,
    output logic [SIZE_BITS-1:0]          room_left,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pfa_pkg::CFG_DATA_W-1:0] cfg_data
);

    pfa_pkg::cfg_t        cfg;
    logic [CNT_W-1:0]     limit;
    logic                 res_valid;
    logic                 res_take;
    logic                 res_granted;
    logic [IDX_W-1:0]     res_idx;
    logic [SIZE_BITS-1:0] res_room;

    pfa_cfg #(
        .MAX_PARTITIONS (MAX_PARTITIONS),
        .CNT_W          (CNT_W)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .limit     (limit)
    );

    pfa_walk #(
        .MAX_PARTITIONS (MAX_PARTITIONS),
        .SIZE_BITS      (SIZE_BITS),
        .IDX_W          (IDX_W),
        .CNT_W          (CNT_W)
    ) u_walk (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .part_index  (part_index),
        .part_size   (part_size),
        .proc_size   (proc_size),
        .cfg         (cfg),
        .limit       (limit),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res_granted (res_granted),
        .res_idx     (res_idx),
        .res_room    (res_room)
    );

    pfa_outreg #(
        .SIZE_BITS (SIZE_BITS),
        .IDX_W     (IDX_W)
    ) u_outreg (
        .clk          (clk),
        .rst_n        (rst_n),
        .res_valid    (res_valid),
        .res_take     (res_take),
        .res_granted  (res_granted),
        .res_idx      (res_idx),
        .res_room     (res_room),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .granted      (granted),
        .placed_index (placed_index),
        .room_left    (room_left)
    );

endmodule

@@ verif/tb_top.sv @@
module tb_top;

    localparam int NUM_PARTS  = pfa_pkg::MAX_PARTITIONS_DEF;
    localparam int SZ_W       = pfa_pkg::SIZE_BITS_DEF;
    localparam int IDX_W      = $clog2(NUM_PARTS);
    localparam int AGE_W      = pfa_pkg::AGE_W;
    localparam int POLICY_W   = pfa_pkg::POLICY_W;
    localparam int HOLD_W     = pfa_pkg::HOLD_W;
    localparam int COUNT_W    = pfa_pkg::COUNT_W;
    localparam int CFG_IDX_W  = pfa_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = pfa_pkg::CFG_DATA_W;

    typedef struct packed {
        logic              granted;
        logic [IDX_W-1:0]  idx;
        logic [SZ_W-1:0]   room;
    } answer_t;

    class partition_tracker;
        logic [SZ_W-1:0]     part_sz[NUM_PARTS];
        logic [SZ_W-1:0]     occ[NUM_PARTS];
        logic [AGE_W-1:0]    age[NUM_PARTS];
        logic [IDX_W-1:0]    resume;
        logic [POLICY_W-1:0] policy;
        logic [HOLD_W-1:0]   hold;
        logic [COUNT_W-1:0]  count;
        answer_t             expected_answers[$];
        int                  errors;
        int                  loads;
        int                  allocs;
        int                  grants[4];
        int                  settings;

        function new();
            for (int i = 0; i < NUM_PARTS; i++)
            begin
                part_sz[i] = '0;
                occ[i]     = '0;
                age[i]     = '0;
            end
            resume   = '0;
            policy   = pfa_pkg::POLICY_RESET;
            hold     = pfa_pkg::HOLD_RESET;
            count    = pfa_pkg::COUNT_RESET;
            errors   = 0;
            loads    = 0;
            allocs   = 0;
            settings = 0;
            for (int p = 0; p < 4; p++)
                grants[p] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] ridx, logic [CFG_DATA_W-1:0] val);
            case (ridx)
                pfa_pkg::CFG_FIT_POLICY:      policy = val[POLICY_W-1:0];
                pfa_pkg::CFG_HOLD_TIME:       hold   = val[HOLD_W-1:0];
                pfa_pkg::CFG_PARTITION_COUNT: count  = val[COUNT_W-1:0];
                default: ;
            endcase
        endfunction

        function int room(int i);
            return (part_sz[i] >= occ[i]) ? int'(part_sz[i] - occ[i]) : 0;
        endfunction

        // true when the partition is released
        function bit age_step(int i);
            int nxt;
            nxt = int'(age[i]) + 1;
            if (nxt > int'(hold))
            begin
                occ[i] = '0;
                age[i] = '0;
                return 1'b1;
            end
            age[i] = nxt[AGE_W-1:0];
            return 1'b0;
        endfunction

        function void place(int i, logic [SZ_W-1:0] sz);
            occ[i] = occ[i] + sz;
            age[i] = AGE_W'(1);
        endfunction

        function int walk_lim();
            return (int'(count) > NUM_PARTS) ? NUM_PARTS : int'(count);
        endfunction

        function bit walk_resume(logic [SZ_W-1:0] sz, bit split, output int pick);
            int lim;
            int r;
            lim  = walk_lim();
            pick = 0;
            for (int i = int'(resume); i < lim; i++)
            begin
                if (occ[i] != 0)
                begin
                    if (age_step(i))
                        continue;
                    if (split && room(i) >= int'(sz))
                    begin
                        place(i, sz);
                        resume = i[IDX_W-1:0];
                        pick   = i;
                        return 1'b1;
                    end
                end
                else
                begin
                    r = room(i);
                    if (int'(sz) <= r && (split || r != 0))
                    begin
                        place(i, sz);
                        resume = i[IDX_W-1:0];
                        pick   = i;
                        return 1'b1;
                    end
                end
            end
            resume = '0;
            return 1'b0;
        endfunction

        function bit walk_all(logic [SZ_W-1:0] sz, bit want_large, output int pick);
            int lim;
            int r;
            int pick_room;
            bit found;
            lim       = walk_lim();
            pick      = 0;
            pick_room = 0;
            found     = 1'b0;
            for (int i = 0; i < lim; i++)
            begin
                if (occ[i] != 0)
                    void'(age_step(i));
                else
                begin
                    r = room(i);
                    if (r >= int'(sz))
                    begin
                        if (!found || (want_large ? r > pick_room : r < pick_room))
                        begin
                            found     = 1'b1;
                            pick      = i;
                            pick_room = r;
                        end
                    end
                end
            end
            if (found)
                place(pick, sz);
            return found;
        endfunction

        function void note_request(logic rt, logic [IDX_W-1:0] pi, logic [SZ_W-1:0] ps,
                                   logic [SZ_W-1:0] pr);
            answer_t ans;
            bit      ok;
            int      pick;
            ans  = '0;
            pick = 0;
            if (rt == pfa_pkg::REQ_LOAD)
            begin
                part_sz[pi] = ps;
                occ[pi]     = '0;
                age[pi]     = '0;
                ans.granted = 1'b1;
                ans.idx     = pi;
                ans.room    = ps;
                loads++;
            end
            else
            begin
                case (policy)
                    pfa_pkg::POLICY_FIRST: ok = walk_resume(pr, 1'b0, pick);
                    pfa_pkg::POLICY_BEST:  ok = walk_all(pr, 1'b0, pick);
                    pfa_pkg::POLICY_WORST: ok = walk_all(pr, 1'b1, pick);
                    default:               ok = walk_resume(pr, 1'b1, pick);
                endcase
                if (ok)
                begin
                    ans.granted = 1'b1;
                    ans.idx     = pick[IDX_W-1:0];
                    ans.room    = SZ_W'(room(pick));
                    grants[policy]++;
                end
                allocs++;
            end
            expected_answers.push_back(ans);
        endfunction

        function void check_answer(logic g, logic [IDX_W-1:0] pi, logic [SZ_W-1:0] rl);
            answer_t exp_ans;
            if (expected_answers.size() == 0)
            begin
                $error("unexpected result word: granted %0d index %0d room %0d", g, pi, rl);
                errors++;
                return;
            end
            exp_ans = expected_answers.pop_front();
            if (g !== exp_ans.granted)
            begin
                $error("granted: expected %0d, got %0d", exp_ans.granted, g);
                errors++;
            end
            if (pi !== exp_ans.idx)
            begin
                $error("placed_index: expected %0d, got %0d", exp_ans.idx, pi);
                errors++;
            end
            if (rl !== exp_ans.room)
            begin
                $error("room_left: expected %0d, got %0d", exp_ans.room, rl);
                errors++;
            end
        endfunction

        function int pending();
            return expected_answers.size();
        endfunction
    endclass

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_stall;
    logic                  req_type     = 1'b0;
    logic [IDX_W-1:0]      part_index   = '0;
    logic [SZ_W-1:0]       part_size    = '0;
    logic [SZ_W-1:0]       proc_size    = '0;
    logic                  out_valid;
    logic                  out_stall    = 1'b0;
    logic                  granted;
    logic [IDX_W-1:0]      placed_index;
    logic [SZ_W-1:0]       room_left;
    logic                  cfg_valid    = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index    = '0;
    logic [CFG_DATA_W-1:0] cfg_data     = '0;

    int send_idle_pct = 0;
    int rcv_idle_pct  = 0;
    int hold_request  = 0;
    int hold_left     = 0;

    partition_tracker tracker;

    partition_fit_allocator_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .part_index   (part_index),
        .part_size    (part_size),
        .proc_size    (proc_size),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .granted      (granted),
        .placed_index (placed_index),
        .room_left    (room_left),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: check accepted words, then pick the next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_answer(granted, placed_index, room_left);
        if (hold_request > 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rcv_idle_pct);
    end

    task automatic send_word(logic rt, logic [IDX_W-1:0] pi, logic [SZ_W-1:0] ps,
                             logic [SZ_W-1:0] pr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= rt;
        part_index <= pi;
        part_size  <= ps;
        proc_size  <= pr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_request(rt, pi, ps, pr);
    endtask

    task automatic load_part(int idx, int sz);
        send_word(pfa_pkg::REQ_LOAD, idx[IDX_W-1:0], sz[SZ_W-1:0], SZ_W'($urandom_range(255)));
    endtask

    task automatic alloc_proc(int sz);
        send_word(pfa_pkg::REQ_ALLOC, IDX_W'($urandom_range(NUM_PARTS - 1)),
                  SZ_W'($urandom_range(255)), sz[SZ_W-1:0]);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] ridx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= ridx;
        cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        tracker.set_reg(ridx, val[CFG_DATA_W-1:0]);
        @(posedge clk);
    endtask

    task automatic set_cfg(logic [POLICY_W-1:0] pol, int hold, int cnt);
        drain();
        write_reg(pfa_pkg::CFG_FIT_POLICY, int'(pol));
        write_reg(pfa_pkg::CFG_HOLD_TIME, hold);
        write_reg(pfa_pkg::CFG_PARTITION_COUNT, cnt);
        tracker.settings++;
    endtask

    initial
    begin
        int phase_items;
        int n;
        int sel;
        int hold;
        int cnt;
        int sz;
        int pol;
        tracker = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        send_idle_pct = 9;
        rcv_idle_pct  = 62;
        set_cfg(pfa_pkg::POLICY_FIRST, 5, NUM_PARTS);
        for (int i = 0; i < NUM_PARTS; i++)
        begin
            if (i == 0)
                sz = 0;
            else if (i == 1 || i == 50 || i == NUM_PARTS - 1)
                sz = 255;
            else
                sz = 8 + (i % 16) * 3;
            load_part(i, sz);
        end
        alloc_proc(0);
        alloc_proc(200);
        alloc_proc(200);
        set_cfg(pfa_pkg::POLICY_FIRST, 5, 20);
        alloc_proc(5);
        alloc_proc(5);
        set_cfg(pfa_pkg::POLICY_FIRST, 1, 20);
        alloc_proc(5);
        alloc_proc(5);
        alloc_proc(5);
        set_cfg(pfa_pkg::POLICY_FIRST, 5, 0);
        alloc_proc(1);
        set_cfg(pfa_pkg::POLICY_BEST, 15, 127);
        alloc_proc(10);
        alloc_proc(255);
        alloc_proc(10);
        set_cfg(pfa_pkg::POLICY_WORST, 15, NUM_PARTS);
        alloc_proc(100);
        alloc_proc(0);
        alloc_proc(255);
        set_cfg(pfa_pkg::POLICY_SPLIT, 0, 30);
        alloc_proc(3);
        alloc_proc(3);
        set_cfg(pfa_pkg::POLICY_SPLIT, 15, 30);
        alloc_proc(3);
        alloc_proc(3);
        alloc_proc(3);
        alloc_proc(0);
        alloc_proc(255);

        // random part, three idle profiles
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 9;
                    rcv_idle_pct  = 62;
                end
                1:
                begin
                    send_idle_pct = 62;
                    rcv_idle_pct  = 9;
                end
                default:
                begin
                    send_idle_pct = 0;
                    rcv_idle_pct  = 0;
                end
            endcase
            phase_items = 0;
            for (int s = 0; phase_items < 230; s++)
            begin
                sel = $urandom_range(9);
                hold = (sel == 0) ? 0 : (sel == 1) ? 1 : (sel == 2) ? 15 : $urandom_range(1, 15);
                sel = $urandom_range(11);
                case (sel)
                    0:       cnt = 0;
                    1:       cnt = 1;
                    2:       cnt = 2;
                    3, 4:    cnt = NUM_PARTS;
                    5:       cnt = $urandom_range(NUM_PARTS + 1, 127);
                    default: cnt = $urandom_range(1, NUM_PARTS);
                endcase
                pol = $urandom_range(3);
                set_cfg(pol[POLICY_W-1:0], hold, cnt);
                if (phase == 0 && s == 1)
                    hold_request = 400;
                n = $urandom_range(30, 64);
                for (int k = 0; k < n; k++)
                begin
                    if ($urandom_range(4) == 0)
                    begin
                        sel = $urandom_range(5);
                        sz = (sel == 0) ? 0 : (sel == 1) ? 255 :
                             (sel == 2) ? $urandom_range(20, 120) : $urandom_range(255);
                        load_part($urandom_range(NUM_PARTS - 1), sz);
                    end
                    else
                    begin
                        sel = $urandom_range(9);
                        sz = (sel == 0) ? 0 : (sel == 1) ? 255 :
                             (sel < 6) ? $urandom_range(1, 40) : $urandom_range(255);
                        alloc_proc(sz);
                    end
                    phase_items++;
                end
            end
        end

        drain();
        repeat (70) @(posedge clk);
        $display("covered %0d loads and %0d allocations over %0d register settings",
                 tracker.loads, tracker.allocs, tracker.settings);
        $display("grants by policy: first %0d, best %0d, worst %0d, split %0d",
                 tracker.grants[0], tracker.grants[1], tracker.grants[2], tracker.grants[3]);
        if (tracker.errors == 0 && tracker.pending() == 0)
            $display("PASS partition_fit_allocator_core");
        else
            $display("FAIL partition_fit_allocator_core");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("FAIL partition_fit_allocator_core");
        $finish;
    end

endmodule
